// ===== hdl/timed_event_queue_macros.svh =====
// Assertion macros used by the timed event queue top level.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define TEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEQ_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TEQ_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/teq_pkg.sv =====
// Types and constants for the timed event queue.
`default_nettype none
package teq_pkg;
  localparam int HANDLE_W = 8;
  localparam int TIMER_W  = 17;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // cell operations broadcast along the row
  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd3;
  localparam logic [OP_W-1:0] OP_ARM        = 3'd4;
  localparam logic [OP_W-1:0] OP_STEP       = 3'd5;
  localparam logic [OP_W-1:0] OP_TAKE       = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  typedef struct packed {
    logic                       valid;
    logic [HANDLE_W-1:0]        handle;
    logic signed [TIMER_W-1:0]  timer;
  } teq_entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    teq_entry_t      fresh;
  } teq_ctl_t;

  typedef struct packed {
    logic tok;
    logic ready;
    logic zero;
  } teq_probe_t;
endpackage
`default_nettype wire

// ===== hdl/teq_cell.sv =====
// One queue slot: holds an entry and a search mark, shifts with its neighbors.
`default_nettype none
module teq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  teq_pkg::teq_ctl_t  ctl,
  input  teq_pkg::teq_entry_t prev_ent,
  input  teq_pkg::teq_entry_t next_ent,
  input  logic               prev_thermo,
  output teq_pkg::teq_entry_t ent,
  output logic               thermo,
  output teq_pkg::teq_probe_t probe
);
  import teq_pkg::*;

  teq_entry_t ent_r, ent_nxt;
  logic       thermo_r, thermo_nxt;

  always_comb begin
    ent_nxt    = ent_r;
    thermo_nxt = thermo_r;
    case (ctl.op)
      OP_PUSH_FRONT: ent_nxt = prev_ent;
      OP_PUSH_BACK: begin
        if (!ent_r.valid && prev_ent.valid) ent_nxt = ctl.fresh;
      end
      OP_TICK: begin
        if (ent_r.valid && (ent_r.timer > 0)) ent_nxt.timer = ent_r.timer - 17'sd1;
      end
      OP_ARM:  thermo_nxt = 1'b1;
      OP_STEP: thermo_nxt = prev_thermo;
      OP_TAKE: begin
        thermo_nxt = 1'b0;
        if (thermo_r) ent_nxt = next_ent;
      end
      OP_CLEAR: thermo_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      thermo_r    <= 1'b0;
    end else begin
      ent_r    <= ent_nxt;
      thermo_r <= thermo_nxt;
    end
  end

  // search token sits on the first marked cell, if that cell holds a valid entry
  assign probe.tok   = thermo_r & ~prev_thermo & ent_r.valid;
  assign probe.ready = probe.tok & (ent_r.timer <= 0);
  assign probe.zero  = (ent_r.timer == 0);
  assign ent         = ent_r;
  assign thermo      = thermo_r;
endmodule
`default_nettype wire

// ===== hdl/timed_event_queue.sv =====
// Timed event queue: top level with request control and the row of cells.
//
// Requests arrive on in_* (tuser = request kind, tdata = priority, handle,
// delay). Every accepted request yields exactly one result on out_*
// (tuser = status, tdata = popped handle and fired flag).
// Entries live in a row of POOL_DEPTH cells kept in list order, valid from
// cell 0 upward. Push and tick need no search: the result is in the
// output register the cycle after acceptance. A pop arms a search token
// that walks the row one cell per cycle; the result is loaded when the
// token reaches the first ready cell (timer <= 0), or with status EMPTY
// when the token passes the last valid entry. The token walk sets how
// long a pop takes.
// A new request is taken once the block is idle and the output register
// is empty or being drained. While the receiver stalls, the result waits
// in the output register and no further request is taken.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
`include "timed_event_queue_macros.svh"
module timed_event_queue #(
  parameter int POOL_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // prio_front[0], event_handle[8:1], delay[25:9]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // popped_handle[7:0], fired[8]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import teq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SEEK = 1'b1;

  logic state_r, state_nxt;

  teq_entry_t ent_w   [POOL_DEPTH];
  logic       thermo_w[POOL_DEPTH];
  teq_probe_t probe_w [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] valid_vec;

  teq_ctl_t   ctl;
  teq_entry_t fresh;
  logic       hp;
  logic [REQ_W-1:0] req;
  logic       in_acc;
  logic       full;

  logic                tok_any, hit, hit_zero;
  logic [HANDLE_W-1:0] hit_handle;

  logic                out_valid_r;
  logic [15:0]         out_tdata_r;
  logic [STATUS_W-1:0] out_tuser_r;
  logic                load;
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_fired;

  assign req          = in_tuser;
  assign hp           = in_tdata[0];
  assign fresh.valid  = 1'b1;
  assign fresh.handle = in_tdata[8:1];
  assign fresh.timer  = in_tdata[25:9];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = ent_w[POOL_DEPTH-1].valid;

  genvar g;
  generate
    for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
      teq_entry_t prev_e, next_e;
      logic       prev_t;
      if (g == 0) begin : g_first
        assign prev_e = fresh;
        assign prev_t = 1'b0;
      end else begin : g_mid
        assign prev_e = ent_w[g-1];
        assign prev_t = thermo_w[g-1];
      end
      if (g == POOL_DEPTH - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = ent_w[g+1];
      end
      teq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_ent   (prev_e),
        .next_ent   (next_e),
        .prev_thermo(prev_t),
        .ent        (ent_w[g]),
        .thermo     (thermo_w[g]),
        .probe      (probe_w[g])
      );
      assign valid_vec[g] = ent_w[g].valid;
    end
  endgenerate

  always_comb begin
    tok_any    = 1'b0;
    hit        = 1'b0;
    hit_zero   = 1'b0;
    hit_handle = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      tok_any    = tok_any | probe_w[i].tok;
      hit        = hit | probe_w[i].ready;
      hit_zero   = hit_zero | (probe_w[i].ready & probe_w[i].zero);
      hit_handle = hit_handle | (probe_w[i].ready ? ent_w[i].handle : '0);
    end
  end

  always_comb begin
    ctl.op     = OP_NONE;
    ctl.fresh  = fresh;
    state_nxt  = state_r;
    load       = 1'b0;
    res_status = ST_DONE;
    res_handle = '0;
    res_fired  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_PUSH: begin
              load = 1'b1;
              if (full) res_status = ST_FULL;
              else      ctl.op = hp ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end
            REQ_POP: begin
              ctl.op    = OP_ARM;
              state_nxt = S_SEEK;
            end
            REQ_TICK: begin
              ctl.op = OP_TICK;
              load   = 1'b1;
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_SEEK: begin
        if (hit) begin
          ctl.op     = OP_TAKE;
          load       = 1'b1;
          res_handle = hit_handle;
          res_fired  = hit_zero;
          state_nxt  = S_IDLE;
        end else if (!tok_any) begin
          ctl.op     = OP_CLEAR;
          load       = 1'b1;
          res_status = ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          ctl.op = OP_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {7'd0, res_fired, res_handle};
      out_tuser_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  function automatic logic [POOL_DEPTH-1:0] probe_w_tok_vec();
    logic [POOL_DEPTH-1:0] v;
    for (int i = 0; i < POOL_DEPTH; i++) v[i] = probe_w[i].tok;
    return v;
  endfunction

  `TEQ_ASSERT(a_seek_out_empty, clk, rst_n, (state_r == S_SEEK) |-> !out_valid_r, "result pending during search")
  `TEQ_ASSERT(a_one_token, clk, rst_n, (state_r == S_SEEK) |-> $onehot0(probe_w_tok_vec()), "more than one search token")
  `TEQ_ASSERT(a_push_grows, clk, rst_n, (in_acc && req == REQ_PUSH && !full) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1), "push did not add an entry")
  `TEQ_ASSERT(a_pop_seeks, clk, rst_n, (in_acc && req == REQ_POP) |=> (state_r == S_SEEK), "pop did not start a search")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for timed_event_queue: directed request table, then random traffic.
module testbench;
  import teq_pkg::*;

  localparam int POOL = 32;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 24;
  localparam int PHASE_REQUESTS = 306;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic                fired;
  } pop_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic                      hp;
    logic [HANDLE_W-1:0]       handle;
    logic signed [TIMER_W-1:0] delay;
    logic                      typed;
    pop_result_t               res;
  } stim_row_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_EMPTY, 8'h00, 1'b0}},
    '{REQ_TICK,   1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_UNUSED, 1'b1, 8'hFF, -17'sd1,    1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_PUSH,   1'b0, 8'hFF, 17'sd0,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'hFF, 1'b1}},
    '{REQ_PUSH,   1'b1, 8'h00, -17'sd1,    1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_PUSH,   1'b0, 8'h5A, 17'sd65535, 1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_PUSH,   1'b0, 8'hA5, 17'sd1,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    // most negative timer, linked at the front
    '{REQ_PUSH,   1'b1, 8'h3C, 17'h10000,  1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'h3C, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_EMPTY, 8'h00, 1'b0}},
    '{REQ_TICK,   1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    // tail entry popped, tail must move back
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'hA5, 1'b1}},
    '{REQ_PUSH,   1'b0, 8'h11, 17'sd2,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_PUSH,   1'b1, 8'h22, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_TICK,   1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_TICK,   1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_UNUSED, 1'b0, 8'h00, 17'sd0,     1'b1, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_PUSH,   1'b0, 8'h80, -17'sd2,    1'b0, '{ST_DONE,  8'h00, 1'b0}},
    '{REQ_POP,    1'b0, 8'h00, 17'sd0,     1'b0, '{ST_DONE,  8'h00, 1'b0}}
  };

  localparam int SEND_IDLE [4]  = '{0, 74, 0, 26};
  localparam int RECV_STALL [4] = '{0, 0, 74, 26};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  timed_event_queue #(.POOL_DEPTH(POOL)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // queue model state
  logic [HANDLE_W-1:0] ent_handle [POOL];
  int                  ent_timer  [POOL];
  logic [4:0]          ent_link   [POOL];
  logic [4:0]          q_head;
  logic [4:0]          q_tail;
  logic [4:0]          free_ptr;
  int                  q_count;

  pop_result_t pending_results [$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int mismatch_count;
  int watchdog_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic pop_result_t predict_request(input logic [REQ_W-1:0] req, input logic hp,
                                                  input logic [HANDLE_W-1:0] hnd,
                                                  input logic signed [TIMER_W-1:0] dly);
    pop_result_t r;
    logic [4:0]  e;
    logic [4:0]  cur;
    logic [4:0]  prev;
    logic        found;
    r = '{ST_DONE, 8'h00, 1'b0};
    case (req)
      REQ_PUSH: begin
        if (q_count >= POOL) begin
          r.status = ST_FULL;
        end else begin
          e = free_ptr;
          free_ptr = ent_link[e];
          ent_handle[e] = hnd;
          ent_timer[e] = dly;
          if (q_count == 0) begin
            q_head = e;
            q_tail = e;
          end else if (hp) begin
            ent_link[e] = q_head;
            q_head = e;
          end else begin
            ent_link[q_tail] = e;
            q_tail = e;
          end
          q_count++;
        end
      end
      REQ_POP: begin
        r.status = ST_EMPTY;
        cur = q_head;
        prev = cur;
        found = 1'b0;
        for (int i = 0; i < q_count && !found; i++) begin
          if (ent_timer[cur] <= 0) begin
            found = 1'b1;
            r = '{ST_DONE, ent_handle[cur], ent_timer[cur] == 0};
            if (i == 0) q_head = ent_link[cur];
            else ent_link[prev] = ent_link[cur];
            if (i + 1 == q_count) q_tail = prev;
            q_count--;
            ent_link[cur] = free_ptr;
            free_ptr = cur;
          end else begin
            prev = cur;
            cur = ent_link[cur];
          end
        end
      end
      REQ_TICK: begin
        cur = q_head;
        for (int i = 0; i < q_count; i++) begin
          if (ent_timer[cur] > 0) ent_timer[cur]--;
          cur = ent_link[cur];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [REQ_W-1:0] req, input logic hp,
                              input logic [HANDLE_W-1:0] hnd,
                              input logic signed [TIMER_W-1:0] dly,
                              input logic typed, input pop_result_t typed_res);
    pop_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = req;
    in_tdata = {6'd0, dly, hnd, hp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_request(req, hp, hnd, dly);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  // receiver: random stalls plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_tready = 1'b0;
        hold_request--;
      end else begin
        out_tready = rst_n && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pop_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: status %0d handle %02h fired %0d",
                   $time, out_tuser, out_tdata[7:0], out_tdata[8]);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.status || out_tdata[7:0] != want.handle ||
            out_tdata[8] != want.fired) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected status %0d handle %02h fired %0d, got %0d %02h %0d",
                     $time, want.status, want.handle, want.fired,
                     out_tuser, out_tdata[7:0], out_tdata[8]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watchdog_count <= 0;
    end else if (watchdog_count >= WATCHDOG_LIMIT) begin
      $display("** timed_event_queue: FAILED **");
      $finish;
    end else begin
      watchdog_count <= watchdog_count + 1;
    end
  end

  initial begin : stimulus
    int                        sent;
    int                        burst;
    int                        mode;
    int                        len;
    int                        pick;
    logic [REQ_W-1:0]          req;
    logic                      hp;
    logic [HANDLE_W-1:0]       hnd;
    logic signed [TIMER_W-1:0] dly;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    for (int i = 0; i < POOL; i++) begin
      ent_handle[i] = '0;
      ent_timer[i] = 0;
      ent_link[i] = 5'((i + 1) % POOL);
    end
    q_head = '0;
    q_tail = '0;
    free_ptr = '0;
    q_count = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(DIRECTED[i].req, DIRECTED[i].hp, DIRECTED[i].handle,
                   DIRECTED[i].delay, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      sent = 0;
      burst = 0;
      while (sent < PHASE_REQUESTS) begin
        // bursts rotate: fill toward full, mixed, drain toward empty
        mode = burst % 3;
        len = $urandom_range(40, 70);
        for (int k = 0; k < len && sent < PHASE_REQUESTS; k++) begin
          pick = $urandom_range(99);
          case (mode)
            0: req = pick < 85 ? REQ_PUSH : pick < 93 ? REQ_POP : pick < 99 ? REQ_TICK
                                                                            : REQ_UNUSED;
            1: req = pick < 40 ? REQ_PUSH : pick < 70 ? REQ_POP : pick < 98 ? REQ_TICK
                                                                            : REQ_UNUSED;
            default: req = pick < 9 ? REQ_PUSH : pick < 64 ? REQ_POP : pick < 99 ? REQ_TICK
                                                                                 : REQ_UNUSED;
          endcase
          hp = 1'($urandom);
          hnd = 8'($urandom);
          pick = $urandom_range(99);
          if (pick < 45) dly = 17'($urandom_range(4));
          else if (pick < 60) dly = 17'sd0;
          else if (pick < 70) dly = -17'sd1;
          else if (pick < 80) dly = {1'b1, 16'($urandom)};
          else if (pick < 92) dly = 17'($urandom_range(5, 40));
          else dly = {1'b0, 16'($urandom)};
          send_request(req, hp, hnd, dly, 1'b0, '0);
          sent++;
          if (ph == 0 && sent == 150) hold_request = HOLD_OFF_CYCLES;
        end
        burst++;
        if (burst == 4) drain_results();
      end
      drain_results();
    end

    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("** timed_event_queue: PASSED **");
    else
      $display("** timed_event_queue: FAILED **");
    $finish;
  end

endmodule

// ===== timed_event_queue.f =====
+incdir+hdl
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/timed_event_queue.sv
bench/testbench.sv
